// File: design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register codes, structs and saturation helper for the
// Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 13;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 29;
    localparam int ITER_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CFG_IDX_W  = 3;

    // Escape threshold 4.0 squared-scale; unreachable when it does not fit
    localparam bit            CAN_ESCAPE = (2 * FRAC_BITS + 2) < PROD_W;
    localparam logic [PROD_W-1:0] ESC_THRESH =
        CAN_ESCAPE ? (PROD_W'(4) << (2 * FRAC_BITS)) : '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RE_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RE_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IM_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd4;

    // Reset values: -2.5, 1.25, default steps, 1000 iterations
    localparam logic signed [DATA_W-1:0] RST_RE_MIN     = -32'sd671088640;
    localparam logic signed [DATA_W-1:0] RST_IM_MAX     = 32'sd335544320;
    localparam logic [STEP_W-1:0]        RST_RE_STEP    = 29'd122350;
    localparam logic [STEP_W-1:0]        RST_IM_STEP    = 29'd155381;
    localparam logic [ITER_W-1:0]        RST_ITER_LIMIT = 16'd1000;

    typedef struct packed {
        logic signed [DATA_W-1:0] re_min;
        logic signed [DATA_W-1:0] im_max;
        logic [STEP_W-1:0]        re_step;
        logic [STEP_W-1:0]        im_step;
        logic [ITER_W-1:0]        iter_limit;
    } t_cfg;

    typedef struct packed {
        logic [ITER_W-1:0]        iteration_count;
        logic signed [DATA_W-1:0] final_re;
        logic signed [DATA_W-1:0] final_im;
        logic                     escaped;
    } t_result;

    // Clamp a 65-bit signed sum to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W:0] v);
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        hi = (PROD_W+1)'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - (PROD_W+1)'(1);
        if (v > hi) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/mbe_pixel_if.sv
// ----------------------------------------------------------------------------
// mbe_pixel_if
// Pixel coordinate channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [mbe_pkg::COORD_BITS-1:0]  pixel_x;
    logic [mbe_pkg::COORD_BITS-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

// File: design/mbe_result_if.sv
// ----------------------------------------------------------------------------
// mbe_result_if
// Escape-time result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_result_if;
    logic                               valid;
    logic                               ready;
    logic [mbe_pkg::ITER_W-1:0]         iteration_count;
    logic signed [mbe_pkg::DATA_W-1:0]  final_re;
    logic signed [mbe_pkg::DATA_W-1:0]  final_im;
    logic                               escaped;

    modport source (output valid, output iteration_count, output final_re,
                    output final_im, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input final_re,
                    input final_im, input escaped, output ready);
endinterface

`default_nettype wire

// File: design/mbe_cfg_if.sv
// ----------------------------------------------------------------------------
// mbe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mbe_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mbe_pkg::CFG_IDX_W-1:0]     index;
    logic [mbe_pkg::DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/mbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbe_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_cfg_regs (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mbe_cfg_if.sink       i_cfg,
    output mbe_pkg::t_cfg o_cfg
);

    mbe_pkg::t_cfg r_cfg;
    mbe_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mbe_pkg::CFG_RE_MIN:     n_cfg.re_min     = i_cfg.data;
                mbe_pkg::CFG_IM_MAX:     n_cfg.im_max     = i_cfg.data;
                mbe_pkg::CFG_RE_STEP:    n_cfg.re_step    = i_cfg.data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_IM_STEP:    n_cfg.im_step    = i_cfg.data[mbe_pkg::STEP_W-1:0];
                mbe_pkg::CFG_ITER_LIMIT: n_cfg.iter_limit = i_cfg.data[mbe_pkg::ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.re_min     <= mbe_pkg::RST_RE_MIN;
            r_cfg.im_max     <= mbe_pkg::RST_IM_MAX;
            r_cfg.re_step    <= mbe_pkg::RST_RE_STEP;
            r_cfg.im_step    <= mbe_pkg::RST_IM_STEP;
            r_cfg.iter_limit <= mbe_pkg::RST_ITER_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: design/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul
// Shared 32x32 signed multiplier with a registered full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
    input  wire logic                              i_clk,
    input  wire logic signed [mbe_pkg::DATA_W-1:0] i_a,
    input  wire logic signed [mbe_pkg::DATA_W-1:0] i_b,
    output logic signed [mbe_pkg::PROD_W-1:0]      o_prod
);

    logic signed [mbe_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mbe_pkg::PROD_W'(i_a) * mbe_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: design/mbe_seq.sv
// ----------------------------------------------------------------------------
// mbe_seq
// Sequencer and datapath: maps the pixel to c, then runs z = z^2 + c on the
// shared multiplier in the states S_MRR, S_MII, S_MRI and S_UPD.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mbe_pkg::t_cfg                     i_cfg,
    input  wire logic                              i_start,
    input  wire logic [mbe_pkg::COORD_BITS-1:0]    i_pixel_x,
    input  wire logic [mbe_pkg::COORD_BITS-1:0]    i_pixel_y,
    output logic                                   o_idle,
    output logic                                   o_done,
    output mbe_pkg::t_result                       o_result,
    input  wire logic                              i_take,
    output logic signed [mbe_pkg::DATA_W-1:0]      o_mul_a,
    output logic signed [mbe_pkg::DATA_W-1:0]      o_mul_b,
    input  wire logic signed [mbe_pkg::PROD_W-1:0] i_mul_prod
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MX   = 9'b000000010,
        S_MY   = 9'b000000100,
        S_CI   = 9'b000001000,
        S_MRR  = 9'b000010000,
        S_MII  = 9'b000100000,
        S_MRI  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [mbe_pkg::COORD_BITS-1:0]    r_x;
    logic [mbe_pkg::COORD_BITS-1:0]    r_y;
    logic signed [mbe_pkg::DATA_W-1:0] r_cr;
    logic signed [mbe_pkg::DATA_W-1:0] r_ci;
    logic signed [mbe_pkg::DATA_W-1:0] r_zr;
    logic signed [mbe_pkg::DATA_W-1:0] r_zi;
    logic signed [mbe_pkg::PROD_W-1:0] r_rr;
    logic signed [mbe_pkg::PROD_W-1:0] r_diff;
    logic [mbe_pkg::ITER_W-1:0]        r_iter;
    logic                              r_esc;

    logic [mbe_pkg::PROD_W-1:0]        mag;
    logic                              hit;
    logic [mbe_pkg::ITER_W-1:0]        iter_inc;
    logic signed [mbe_pkg::PROD_W-1:0] re_shift;
    logic signed [mbe_pkg::PROD_W-1:0] im_shift;
    logic signed [mbe_pkg::DATA_W-1:0] new_re;
    logic signed [mbe_pkg::DATA_W-1:0] new_im;

    assign mag      = r_rr + i_mul_prod;
    assign hit      = mbe_pkg::CAN_ESCAPE && (mag >= mbe_pkg::ESC_THRESH);
    assign iter_inc = r_iter + mbe_pkg::ITER_W'(1);
    assign re_shift = r_diff >>> mbe_pkg::FRAC_BITS;
    assign im_shift = i_mul_prod >>> (mbe_pkg::FRAC_BITS - 1);
    assign new_re   = mbe_pkg::sat32((mbe_pkg::PROD_W+1)'(re_shift)
                                     + (mbe_pkg::PROD_W+1)'(r_cr));
    assign new_im   = mbe_pkg::sat32((mbe_pkg::PROD_W+1)'(im_shift)
                                     + (mbe_pkg::PROD_W+1)'(r_ci));

    // Multiplier operand select
    always_comb begin
        o_mul_a = r_zr;
        o_mul_b = r_zi;
        unique case (r_state)
            S_MX: begin
                o_mul_a = {{(mbe_pkg::DATA_W-mbe_pkg::COORD_BITS){1'b0}}, r_x};
                o_mul_b = {{(mbe_pkg::DATA_W-mbe_pkg::STEP_W){1'b0}}, i_cfg.re_step};
            end
            S_MY: begin
                o_mul_a = {{(mbe_pkg::DATA_W-mbe_pkg::COORD_BITS){1'b0}}, r_y};
                o_mul_b = {{(mbe_pkg::DATA_W-mbe_pkg::STEP_W){1'b0}}, i_cfg.im_step};
            end
            S_MRR: begin
                o_mul_a = r_zr;
                o_mul_b = r_zr;
            end
            S_MII: begin
                o_mul_a = r_zi;
                o_mul_b = r_zi;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_CI;
            S_CI:   n_state = (i_cfg.iter_limit == '0) ? S_DONE : S_MRR;
            S_MRR:  n_state = S_MII;
            S_MII:  n_state = S_MRI;
            S_MRI:  n_state = hit ? S_DONE : S_UPD;
            S_UPD:  n_state = (iter_inc == i_cfg.iter_limit) ? S_DONE : S_MRR;
            S_DONE: if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_x <= i_pixel_x;
                r_y <= i_pixel_y;
            end
            S_MY: r_cr <= mbe_pkg::sat32((mbe_pkg::PROD_W+1)'(i_cfg.re_min)
                                         + (mbe_pkg::PROD_W+1)'(i_mul_prod));
            S_CI: begin
                r_ci   <= mbe_pkg::sat32((mbe_pkg::PROD_W+1)'(i_cfg.im_max)
                                         - (mbe_pkg::PROD_W+1)'(i_mul_prod));
                r_zr   <= '0;
                r_zi   <= '0;
                r_iter <= '0;
                r_esc  <= 1'b0;
            end
            S_MII: r_rr <= i_mul_prod;
            S_MRI: begin
                r_diff <= r_rr - i_mul_prod;
                r_esc  <= hit;
            end
            S_UPD: begin
                r_zr   <= new_re;
                r_zi   <= new_im;
                r_iter <= iter_inc;
            end
            default: ;
        endcase
    end

    assign o_idle                   = (r_state == S_IDLE);
    assign o_done                   = (r_state == S_DONE);
    assign o_result.iteration_count = r_iter;
    assign o_result.final_re        = r_zr;
    assign o_result.final_im        = r_zi;
    assign o_result.escaped         = r_esc;

endmodule

`default_nettype wire

// File: design/mandelbrot_escape_iteration_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration_top
// Mandelbrot escape-time unit: one pixel in, one iteration result out.
// ----------------------------------------------------------------------------
// One pixel at a time. The pixel is mapped to c in states S_MX, S_MY and
// S_CI, then each iteration of z = z^2 + c runs on the single shared 32x32
// multiplier (zr^2, zi^2, zr*zi, update). The pixel channel is ready only
// while the sequencer is idle; a finished result sits in an output register,
// so the next pixel is taken while the previous result waits to be read.
// Configuration is written at any time through the config channel and must
// only change while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_iteration_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mbe_cfg_if.sink      i_cfg,
    mbe_pixel_if.sink    i_pix,
    mbe_result_if.source o_res
);

    mbe_pkg::t_cfg                      cfg;
    mbe_pkg::t_result                   seq_result;
    logic                               seq_idle;
    logic                               seq_done;
    logic                               take;
    logic signed [mbe_pkg::DATA_W-1:0]  mul_a;
    logic signed [mbe_pkg::DATA_W-1:0]  mul_b;
    logic signed [mbe_pkg::PROD_W-1:0]  mul_prod;

    logic                               r_out_valid;
    mbe_pkg::t_result                   r_out;

    mbe_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    mbe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_start    (i_pix.valid),
        .i_pixel_x  (i_pix.pixel_x),
        .i_pixel_y  (i_pix.pixel_y),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_result   (seq_result),
        .i_take     (take),
        .o_mul_a    (mul_a),
        .o_mul_b    (mul_b),
        .i_mul_prod (mul_prod)
    );

    assign i_pix.ready = seq_idle;

    // Output register frees the sequencer as soon as the slot is empty or being read
    assign take = seq_done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= seq_result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.iteration_count = r_out.iteration_count;
    assign o_res.final_re        = r_out.final_re;
    assign o_res.final_im        = r_out.final_im;
    assign o_res.escaped         = r_out.escaped;

    // z starts at zero, so no point escapes before its first iteration
    a_no_escape_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.escaped) |-> (o_res.iteration_count != '0))
        else $error("escaped result with zero iterations");

    // Accepting a pixel starts the sequencer, which then holds off the channel
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("pixel channel ready right after an accept");

    // A result leaves the sequencer only into a free output slot
    a_take_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (o_res.valid && seq_idle))
        else $error("result handoff did not load the output register");

endmodule

`default_nettype wire
